// ----- rtl/euclidean_rhythm_gate_assert.svh -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate assertion macros
// Short forms for the clocked checks of the gate pipeline. They expect clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_RHYTHM_GATE_ASSERT_SVH
`define EUCLIDEAN_RHYTHM_GATE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define ERG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ERG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/erg_pkg.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate package
// Transaction types, register indexes and pipeline status shared by the gate.
// ----------------------------------------------------------------------------
package erg_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int BAR_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register stages from capture to the output register
  localparam int NUM_STAGES = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_BARS     = 3'd0,
    CFG_STEP_COUNT    = 3'd1,
    CFG_PULSE_COUNT   = 3'd2,
    CFG_ROTATION      = 3'd3,
    CFG_FADE_BARS_Q8  = 3'd4,
    CFG_BEATS_PER_BAR = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] bar_number;
    logic [11:0] beat_q8;
  } in_item_t;

  typedef struct packed {
    logic        play;
    logic [19:0] fade_beats_q8;
    logic [15:0] apply_bar;
    logic [3:0]  apply_sixteenth;
  } out_item_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] vld;
    logic [NUM_STAGES-1:0] adv;
  } pipe_stat_t;

endpackage

// ----- rtl/erg_stream_if.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate stream interface
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface erg_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/erg_div_slice.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate divider slice
// A few restoring division steps; chained slices form a pipelined divider.
// ----------------------------------------------------------------------------
module erg_div_slice #(
  parameter int RW  = 8,
  parameter int DW  = 8,
  parameter int QW  = 8,
  parameter int HI  = 7,
  parameter int CNT = 1
) (
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] q_o
);

  localparam int WW = RW + DW + QW;

  logic [WW-1:0] r;
  logic [WW-1:0] d;
  logic [QW-1:0] q;

  // subtract the shifted divisor wherever it fits, top bit first
  always_comb begin
    r = WW'(rem_i);
    d = '0;
    q = q_i;
    for (int s = 0; s < CNT; s++) begin
      if (HI - s >= 0) begin
        d = WW'(den_i) << (HI - s);
        if (r >= d) begin
          r = r - d;
          q = q | (QW'(1) << (HI - s));
        end
      end
    end
  end

  assign rem_o = r[RW-1:0];
  assign q_o   = q;

endmodule

// ----- rtl/erg_pipe_ctl.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate pipeline control
// Valid bits for every stage and the load enables that let bubbles collapse.
// ----------------------------------------------------------------------------
module erg_pipe_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output erg_pkg::pipe_stat_t stat
);

  localparam int N = erg_pkg::NUM_STAGES;

  logic [N-1:0] vld_r;
  logic [N-1:0] vld_nxt;
  logic [N-1:0] adv;
  logic [N-1:0] shifted;

  // a stage may load when the output drains or any stage from it onwards is empty
  always_comb begin
    logic [N-1:0] low;
    for (int i = 0; i < N; i++) begin
      low    = {N{1'b1}} >> (N - i);
      adv[i] = out_ready || !(&(vld_r | low));
    end
  end

  assign shifted = {vld_r[N-2:0], in_valid};

  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < N; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = shifted[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign stat.vld = vld_r;
  assign stat.adv = adv;

endmodule

// ----- rtl/euclidean_rhythm_gate.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate
// Turns a transport position into a play/mute gate following a rotated
// Euclidean rhythm, with fade length, apply bar and sixteenth of the bar.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result side is ready or a stage
// is empty. The work runs through a 13-stage register pipeline (capture, four
// stages of bar remainder / rotation / sixteenth division, rotation sign fold
// and bar scaling, position multiply, two stages of step division, rotate and
// pulse multiply, two stages of pulse remainder, output register). When the
// result side stalls, every stage that has an empty stage ahead of it keeps
// moving, so input transactions are taken until the pipeline is full.
// Write the configuration registers only while no transaction is in flight;
// they are sampled as a transaction is captured.
// ----------------------------------------------------------------------------
`include "euclidean_rhythm_gate_assert.svh"

module euclidean_rhythm_gate #(
  parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF,
  parameter int BAR_BITS  = erg_pkg::BAR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  erg_stream_if.sink                     in_ch,
  erg_stream_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [erg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NS    = erg_pkg::NUM_STAGES;
  localparam int BarW  = (BAR_BITS < 16) ? BAR_BITS : 16;
  localparam int NMax  = (MAX_STEPS < 127) ? MAX_STEPS : 127;
  localparam int NW    = $clog2(NMax + 1);
  localparam int BarC  = (BarW + 3) / 4;
  localparam int StepC = (NW + 1) / 2;
  localparam int CycW  = 22;
  localparam int NumW  = CycW + NW;
  localparam int ProdW = 2 * NW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [8:0]  loop_bars_r;
  logic [6:0]  step_count_r;
  logic [6:0]  pulse_count_r;
  logic [7:0]  rotation_r;
  logic [15:0] fade_bars_q8_r;
  logic [4:0]  beats_per_bar_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_bars_r     <= 9'd4;
      step_count_r    <= 7'd16;
      pulse_count_r   <= 7'd0;
      rotation_r      <= 8'd0;
      fade_bars_q8_r  <= 16'd0;
      beats_per_bar_r <= 5'd4;
    end else if (cfg_we) begin
      case (erg_pkg::cfg_idx_t'(cfg_index))
        erg_pkg::CFG_LOOP_BARS:     loop_bars_r     <= cfg_wdata[8:0];
        erg_pkg::CFG_STEP_COUNT:    step_count_r    <= cfg_wdata[6:0];
        erg_pkg::CFG_PULSE_COUNT:   pulse_count_r   <= cfg_wdata[6:0];
        erg_pkg::CFG_ROTATION:      rotation_r      <= cfg_wdata[7:0];
        erg_pkg::CFG_FADE_BARS_Q8:  fade_bars_q8_r  <= cfg_wdata[15:0];
        erg_pkg::CFG_BEATS_PER_BAR: beats_per_bar_r <= cfg_wdata[4:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  erg_pkg::pipe_stat_t stat;
  logic [NS-1:0]       vld;
  logic [NS-1:0]       adv;

  erg_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat)
  );

  assign vld         = stat.vld;
  assign adv         = stat.adv;
  assign in_ch.ready = adv[0];

  // --------------------------------------------------------------------------
  // Stage 0: capture and normalise the operands
  // --------------------------------------------------------------------------
  logic [4:0]  bpb_nxt;
  logic [8:0]  lb_nxt;
  logic [6:0]  sc_nxt;
  logic [NW-1:0] n_nxt;
  logic [12:0] bar_units;
  logic [11:0] beat_nxt;
  logic [7:0]  rabs_nxt;
  logic [20:0] fade_prod;
  logic [19:0] fade_nxt;

  always_comb begin
    // zero acts as one for beats per bar, loop length and step count
    bpb_nxt   = (beats_per_bar_r == '0) ? 5'd1 : beats_per_bar_r;
    lb_nxt    = (loop_bars_r == '0) ? 9'd1 : loop_bars_r;
    sc_nxt    = (step_count_r == '0) ? 7'd1 : step_count_r;
    n_nxt     = (sc_nxt > 7'(NMax)) ? NW'(NMax) : sc_nxt[NW-1:0];
    // clamp a beat past the end of the bar to its last unit
    bar_units = {bpb_nxt, 8'h00};
    beat_nxt  = (13'(in_ch.payload.beat_q8) >= bar_units) ? 12'(bar_units - 13'd1)
                                                          : in_ch.payload.beat_q8;
    rabs_nxt  = rotation_r[7] ? 8'(8'd0 - rotation_r) : rotation_r;
    // the fade product takes the raw beats per bar and saturates
    fade_prod = 21'(fade_bars_q8_r) * 21'(beats_per_bar_r);
    fade_nxt  = fade_prod[20] ? 20'hFFFFF : fade_prod[19:0];
  end

  logic [15:0]   bar_out_r [0:NS-1];
  logic [19:0]   fade_r    [0:NS-1];
  logic [NW-1:0] n_r       [0:NS-1];
  logic [6:0]    k_r       [0:NS-1];
  logic [4:0]    bpb_r     [0:4];
  logic [8:0]    lb_r      [0:4];
  logic [11:0]   beat_r    [0:5];
  logic          rneg_r    [0:4];
  logic [7:0]    rabs_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      bar_out_r[0] <= 16'(in_ch.payload.bar_number[BarW-1:0]);
      fade_r[0]    <= fade_nxt;
      n_r[0]       <= n_nxt;
      k_r[0]       <= pulse_count_r;
      bpb_r[0]     <= bpb_nxt;
      lb_r[0]      <= lb_nxt;
      beat_r[0]    <= beat_nxt;
      rneg_r[0]    <= rotation_r[7];
      rabs_r       <= rabs_nxt;
    end
  end

  // Advance the fields that ride along to the output untouched.
  for (genvar s = 1; s < NS; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        bar_out_r[s] <= bar_out_r[s-1];
        fade_r[s]    <= fade_r[s-1];
        n_r[s]       <= n_r[s-1];
        k_r[s]       <= k_r[s-1];
      end
    end
  end

  for (genvar s = 1; s <= 4; s++) begin : g_carry_front
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        bpb_r[s]  <= bpb_r[s-1];
        lb_r[s]   <= lb_r[s-1];
        rneg_r[s] <= rneg_r[s-1];
      end
    end
  end

  for (genvar s = 1; s <= 5; s++) begin : g_carry_beat
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        beat_r[s] <= beat_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-4: bar modulo loop length, rotation modulo step count, and the
  // sixteenth of the bar, each a few restoring steps per stage
  // --------------------------------------------------------------------------
  logic [BarW-1:0] bar_rem_r [1:4];
  logic [7:0]      rot_rem_r [1:4];
  logic [11:0]     six_rem_r [1:4];
  logic [3:0]      six_q_r   [1:NS-1];
  logic [13:0]     d_r       [1:7];

  for (genvar j = 0; j < 4; j++) begin : g_front_div
    logic [BarW-1:0] bar_in;
    logic [BarW-1:0] bar_out;
    logic [7:0]      rot_in;
    logic [7:0]      rot_out;
    logic [11:0]     six_in;
    logic [11:0]     six_out;
    logic [3:0]      sixq_in;
    logic [3:0]      sixq_out;

    if (j == 0) begin : g_first
      assign bar_in  = bar_out_r[0][BarW-1:0];
      assign rot_in  = rabs_r;
      assign six_in  = beat_r[0];
      assign sixq_in = '0;
    end else begin : g_next
      assign bar_in  = bar_rem_r[j];
      assign rot_in  = rot_rem_r[j];
      assign six_in  = six_rem_r[j];
      assign sixq_in = six_q_r[j];
    end

    erg_div_slice #(
      .RW(BarW), .DW(9), .QW(BarW), .HI(BarW - 1 - j * BarC), .CNT(BarC)
    ) u_bar (
      .rem_i(bar_in), .den_i(lb_r[j]), .q_i('0), .rem_o(bar_out), .q_o()
    );

    erg_div_slice #(
      .RW(8), .DW(NW), .QW(8), .HI(7 - 2 * j), .CNT(2)
    ) u_rot (
      .rem_i(rot_in), .den_i(n_r[j]), .q_i('0), .rem_o(rot_out), .q_o()
    );

    erg_div_slice #(
      .RW(12), .DW(9), .QW(4), .HI(3 - j), .CNT(1)
    ) u_six (
      .rem_i(six_in), .den_i({bpb_r[j], 4'h0}), .q_i(sixq_in),
      .rem_o(six_out), .q_o(sixq_out)
    );

    always_ff @(posedge clk) begin
      if (adv[j+1]) begin
        bar_rem_r[j+1] <= bar_out;
        rot_rem_r[j+1] <= rot_out;
        six_rem_r[j+1] <= six_out;
        six_q_r[j+1]   <= sixq_out;
      end
    end
  end

  // Loop length in bar units divided by 256: the step divisor.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d_r[1] <= 14'(lb_r[0]) * 14'(bpb_r[0]);
    end
  end

  for (genvar s = 2; s <= 7; s++) begin : g_carry_den
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        d_r[s] <= d_r[s-1];
      end
    end
  end

  for (genvar s = 5; s < NS; s++) begin : g_carry_six
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        six_q_r[s] <= six_q_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: fold the rotation sign, scale the wrapped bar
  // --------------------------------------------------------------------------
  logic [NW-1:0] rot_mod_r [5:8];
  logic [NW-1:0] rot_mod_nxt;
  logic [13:0]   bmb_r;

  always_comb begin
    if (rneg_r[4] && (rot_rem_r[4] != '0)) begin
      rot_mod_nxt = n_r[4] - rot_rem_r[4][NW-1:0];
    end else begin
      rot_mod_nxt = rot_rem_r[4][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      rot_mod_r[5] <= rot_mod_nxt;
      bmb_r        <= 14'(bar_rem_r[4]) * 14'(bpb_r[4]);
    end
  end

  for (genvar s = 6; s <= 8; s++) begin : g_carry_rot
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        rot_mod_r[s] <= rot_mod_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: position within the cycle times the step count
  // --------------------------------------------------------------------------
  logic [CycW-1:0] cyc;
  logic [NumW-1:0] num_r [6:7];

  assign cyc = {bmb_r, 8'h00} + CycW'(beat_r[5]);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      num_r[6] <= NumW'(cyc) * NumW'(n_r[5]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7-8: step index as the quotient by the cycle length
  // --------------------------------------------------------------------------
  logic [NW-1:0]   step_q_r [7:8];
  logic [NumW-1:0] step_rem_a;
  logic [NW-1:0]   step_q_a;
  logic [NW-1:0]   step_q_b;

  erg_div_slice #(
    .RW(NumW), .DW(CycW), .QW(NW), .HI(NW - 1), .CNT(StepC)
  ) u_step_a (
    .rem_i(num_r[6]), .den_i({d_r[6], 8'h00}), .q_i('0),
    .rem_o(step_rem_a), .q_o(step_q_a)
  );

  erg_div_slice #(
    .RW(NumW), .DW(CycW), .QW(NW), .HI(NW - 1 - StepC), .CNT(StepC)
  ) u_step_b (
    .rem_i(num_r[7]), .den_i({d_r[7], 8'h00}), .q_i(step_q_r[7]),
    .rem_o(), .q_o(step_q_b)
  );

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      num_r[7]    <= step_rem_a;
      step_q_r[7] <= step_q_a;
    end
    if (adv[8]) begin
      step_q_r[8] <= step_q_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: rotate the step and multiply by the effective pulse count
  // --------------------------------------------------------------------------
  logic [NW:0]      rot_sum;
  logic [NW-1:0]    rotated;
  logic [NW-1:0]    keff;
  logic [ProdW-1:0] prod_r;

  always_comb begin
    rot_sum = (NW+1)'(step_q_r[8]) + (NW+1)'(rot_mod_r[8]);
    if (rot_sum >= (NW+1)'(n_r[8])) begin
      rotated = NW'(rot_sum - (NW+1)'(n_r[8]));
    end else begin
      rotated = rot_sum[NW-1:0];
    end
    keff = (k_r[8] >= 7'(n_r[8])) ? n_r[8] : k_r[8][NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      prod_r <= ProdW'(rotated) * ProdW'(keff);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 10-11: product modulo the step count
  // --------------------------------------------------------------------------
  logic [ProdW-1:0] prem_r [10:11];
  logic [ProdW-1:0] prem_a;
  logic [ProdW-1:0] prem_b;

  erg_div_slice #(
    .RW(ProdW), .DW(NW), .QW(NW), .HI(NW - 1), .CNT(StepC)
  ) u_pmod_a (
    .rem_i(prod_r), .den_i(n_r[9]), .q_i('0), .rem_o(prem_a), .q_o()
  );

  erg_div_slice #(
    .RW(ProdW), .DW(NW), .QW(NW), .HI(NW - 1 - StepC), .CNT(StepC)
  ) u_pmod_b (
    .rem_i(prem_r[10]), .den_i(n_r[10]), .q_i('0), .rem_o(prem_b), .q_o()
  );

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      prem_r[10] <= prem_a;
    end
    if (adv[11]) begin
      prem_r[11] <= prem_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: Euclidean test and output register
  // A step hits where (r*k mod n) + k reaches n; no pulses never hits, and a
  // pulse count at or above the step count always hits.
  // --------------------------------------------------------------------------
  logic play_nxt;
  logic play_r;

  always_comb begin
    if (k_r[11] == '0) begin
      play_nxt = 1'b0;
    end else if (k_r[11] >= 7'(n_r[11])) begin
      play_nxt = 1'b1;
    end else begin
      play_nxt = (8'(prem_r[11]) + 8'(k_r[11])) >= 8'(n_r[11]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      play_r <= play_nxt;
    end
  end

  assign out_ch.valid                   = vld[12];
  assign out_ch.payload.play            = play_r;
  assign out_ch.payload.fade_beats_q8   = fade_r[12];
  assign out_ch.payload.apply_bar       = bar_out_r[12];
  assign out_ch.payload.apply_sixteenth = six_q_r[12];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ERG_ASSERT_NEXT(a_count_held,
    !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready),
    $stable($countones(vld)), "transaction lost or duplicated in pipeline")
  `ERG_ASSERT_IMPLY(a_bubble_ready, !(&vld), in_ch.ready,
    "input stalled with a bubble in the pipeline")
  `ERG_ASSERT_IMPLY(a_bar_rem_range, vld[4], 32'(bar_rem_r[4]) < 32'(lb_r[4]),
    "bar remainder not below loop length")
  `ERG_ASSERT_IMPLY(a_step_range, vld[8], step_q_r[8] < n_r[8],
    "step index not below step count")
  `ERG_ASSERT_IMPLY(a_pulse_rem_range, vld[11], prem_r[11] < ProdW'(n_r[11]),
    "pulse remainder not below step count")

endmodule

// ----- verif/euclidean_rhythm_gate_test.sv -----
// ----------------------------------------------------------------------------
// Euclidean rhythm gate testbench
// Feeds transport positions through the gate under a series of register
// settings. Each accepted position is scored against a predicted play gate,
// fade length, apply bar and sixteenth. Expected results are kept in order and
// compared field by field. Both channels idle at random, the receiver stalls
// for a long stretch, and the sender drains the pipeline between phases.
// ----------------------------------------------------------------------------
module euclidean_rhythm_gate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import erg_pkg::*;

  localparam int STALL_LIMIT    = 2000;  // cycles with no transaction on either side
  localparam int RX_HOLD_CYCLES = 80;    // well beyond the pipeline depth
  localparam int DRAIN_CYCLES   = NUM_STAGES + 4;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_ITEMS    = 100;
  localparam longint unsigned FADE_CEILING = 64'd1048575;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  erg_stream_if #(.item_t(in_item_t))  in_ch ();
  erg_stream_if #(.item_t(out_item_t)) out_ch ();

  euclidean_rhythm_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file, as last written.
  logic [8:0]        bars_per_loop;
  logic [6:0]        steps_per_loop;
  logic [6:0]        pulses_per_loop;
  logic signed [7:0] step_offset;
  logic [15:0]       fade_len_q8;
  logic [4:0]        beats_in_bar;

  in_item_t  position_q[$];      // positions waiting to be offered
  out_item_t gate_results_q[$];  // predicted results, oldest first

  logic in_taken;     // a transaction went in at the last rising edge
  bit   idle_en;      // random idling on both channels
  int   hold_asked;   // receiver stall requests from the sequencer
  int   hold_granted;
  int   hold_left;
  int   mismatch_count;

  // --------------------------------------------------------------------------
  // Predict the result of one transport position under the shadow registers.
  // --------------------------------------------------------------------------
  function automatic out_item_t predict_gate(in_item_t pos_in);
    longint unsigned bpb, loop_len, n, units, beat, cyc, stp, mag, shift, slot, fade, six;
    longint signed   rot;
    out_item_t       res;
    // Zero loop, zero steps and zero beats per bar all act as one.
    bpb      = (beats_in_bar == 0) ? 1 : beats_in_bar;
    loop_len = (bars_per_loop == 0) ? 1 : bars_per_loop;
    n        = (steps_per_loop == 0) ? 1 : steps_per_loop;
    if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
    // Clamp a beat that runs past the end of the bar.
    units = bpb * 256;
    beat  = pos_in.beat_q8;
    if (beat >= units) beat = units - 1;
    // Wrap the position over the loop and find its step.
    cyc = (units * pos_in.bar_number + beat) % (loop_len * units);
    stp = (cyc * n) / (loop_len * units);
    if (stp > n - 1) stp = n - 1;
    // Negative rotation wraps modulo the step count.
    rot = step_offset;
    mag = (rot < 0) ? -rot : rot;
    if (rot < 0) shift = (n - (mag % n)) % n;
    else shift = mag % n;
    slot = (stp + shift) % n;
    if (pulses_per_loop == 0) res.play = 1'b0;
    else if (pulses_per_loop >= n) res.play = 1'b1;
    else res.play = ((slot * pulses_per_loop) / n) != (((slot + 1) * pulses_per_loop) / n);
    // The fade uses the raw beats per bar and saturates.
    fade = longint'(fade_len_q8) * beats_in_bar;
    if (fade > FADE_CEILING) fade = FADE_CEILING;
    res.fade_beats_q8 = fade[19:0];
    res.apply_bar     = pos_in.bar_number;
    six = beat / (16 * bpb);
    if (six > 15) six = 15;
    res.apply_sixteenth = six[3:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Score any result
  // against the oldest prediction, then record a prediction for any
  // position taken in.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want, got;
    logic      took;
    took = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (gate_results_q.size() == 0) begin
          $error("result with no transaction outstanding: bar %0d", got.apply_bar);
          mismatch_count++;
        end else begin
          want = gate_results_q.pop_front();
          if (got.play !== want.play) begin
            $error("play: expected %0d, got %0d", want.play, got.play);
            mismatch_count++;
          end
          if (got.fade_beats_q8 !== want.fade_beats_q8) begin
            $error("fade_beats_q8: expected %0d, got %0d", want.fade_beats_q8,
                   got.fade_beats_q8);
            mismatch_count++;
          end
          if (got.apply_bar !== want.apply_bar) begin
            $error("apply_bar: expected %0d, got %0d", want.apply_bar, got.apply_bar);
            mismatch_count++;
          end
          if (got.apply_sixteenth !== want.apply_sixteenth) begin
            $error("apply_sixteenth: expected %0d, got %0d", want.apply_sixteenth,
                   got.apply_sixteenth);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        gate_results_q.push_back(predict_gate(in_ch.payload));
        void'(position_q.pop_front());
        took = 1'b1;
      end
    end
    in_taken <= took;
  end

  // --------------------------------------------------------------------------
  // Driver: hold an offered position until it is taken, then offer the next
  // one from the queue unless this cycle idles.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (position_q.size() != 0 && !(idle_en && $urandom_range(99) < 12)) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= position_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pick up a stall request and hold ready low for the whole
  // stretch, otherwise drop ready at random.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_granted != hold_asked) begin
      hold_granted <= hold_asked;
      hold_left    <= RX_HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_en && $urandom_range(99) < 12);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------

  // Write one register and mirror it into the shadow copy.
  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[15:0];
    case (idx)
      CFG_LOOP_BARS:     bars_per_loop   = value[8:0];
      CFG_STEP_COUNT:    steps_per_loop  = value[6:0];
      CFG_PULSE_COUNT:   pulses_per_loop = value[6:0];
      CFG_ROTATION:      step_offset     = value[7:0];
      CFG_FADE_BARS_Q8:  fade_len_q8     = value[15:0];
      CFG_BEATS_PER_BAR: beats_in_bar    = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_rhythm(int lb, int steps, int pulses, int rot, int fade, int bpb);
    write_reg(CFG_LOOP_BARS, lb);
    write_reg(CFG_STEP_COUNT, steps);
    write_reg(CFG_PULSE_COUNT, pulses);
    write_reg(CFG_ROTATION, rot);
    write_reg(CFG_FADE_BARS_Q8, fade);
    write_reg(CFG_BEATS_PER_BAR, bpb);
  endtask

  // Mostly legal settings, now and then the raw extremes of each field.
  task automatic random_rhythm();
    int lb, steps, pulses, bpb;
    lb     = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 511);
    steps  = ($urandom_range(9) < 8) ? $urandom_range(1, 64) : $urandom_range(0, 127);
    pulses = ($urandom_range(9) < 8) ? $urandom_range(0, steps + 1) : $urandom_range(0, 127);
    bpb    = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 31);
    set_rhythm(lb, steps, pulses, $urandom_range(0, 255), $urandom_range(0, 65535), bpb);
  endtask

  task automatic push_position(int unsigned bar, int unsigned beat);
    in_item_t p;
    p.bar_number = bar[15:0];
    p.beat_q8    = beat[11:0];
    position_q.push_back(p);
  endtask

  // Mostly bars near the start of the loop with beats inside the bar; the
  // rest cover the full width of both fields, clamped beats included.
  task automatic push_random_positions(int count);
    int unsigned units, bar, beat;
    units = ((beats_in_bar == 0) ? 1 : beats_in_bar) * 256;
    if (units > 4096) units = 4096;
    repeat (count) begin
      bar  = ($urandom_range(9) < 6) ? $urandom_range(0, 1023) : $urandom_range(0, 65535);
      beat = ($urandom_range(3) != 0) ? $urandom_range(0, units - 1) : $urandom_range(0, 4095);
      push_position(bar, beat);
    end
  endtask

  // Wait until every queued position has gone in and every result has come
  // back, then let the pipeline settle.
  task automatic wait_idle();
    while (position_q.size() != 0 || in_ch.valid || gate_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.payload   = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    idle_en         = 1'b1;
    hold_asked      = 0;
    hold_granted    = 0;
    hold_left       = 0;
    mismatch_count  = 0;
    // Reset values of the registers.
    bars_per_loop   = 9'd4;
    steps_per_loop  = 7'd16;
    pulses_per_loop = 7'd0;
    step_offset     = 8'sd0;
    fade_len_q8     = 16'd0;
    beats_in_bar    = 5'd4;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no pulses, so nothing plays. Cover the field extremes
    // and a beat past the end of the bar.
    push_position(0, 0);
    push_position(65535, 4095);
    push_position(3, 1023);
    push_position(1, 512);
    wait_idle();

    // Three hits over eight steps, rotated backwards: walk every step.
    set_rhythm(4, 8, 3, -3, 16'h0180, 4);
    for (int b = 0; b < 4; b++) begin
      push_position(b, 0);
      push_position(b, 512);
    end
    wait_idle();

    // Zero loop, zero steps, zero beats per bar, more pulses than steps.
    set_rhythm(0, 0, 5, 127, 65535, 0);
    push_position(0, 0);
    push_position(12345, 4095);
    push_position(65535, 255);
    wait_idle();

    // Too many steps, full rotation backwards and a fade that saturates.
    set_rhythm(511, 127, 64, -128, 65535, 31);
    push_position(0, 0);
    push_position(40000, 4095);
    push_position(510, 2000);
    wait_idle();

    // Widest legal loop and bar, a non-trivial pattern.
    set_rhythm(256, 64, 37, 5, 1, 16);
    push_position(65535, 4095);
    push_position(255, 4095);
    push_position(128, 2048);
    push_position(77, 1);
    wait_idle();

    // Random phases, each under fresh settings.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_rhythm();
      // Run a long stretch with no idling on either side.
      idle_en = !(phase >= 4 && phase < 8);
      // Stall the receiver while positions keep coming, so the pipeline fills.
      if (phase == 1 || phase == 14) hold_asked++;
      if (phase == 10) begin
        // Pause the sender until everything is back, then carry on.
        push_random_positions(PHASE_ITEMS / 2);
        wait_idle();
        push_random_positions(PHASE_ITEMS / 2);
      end else begin
        push_random_positions(PHASE_ITEMS);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/erg_pkg.sv
rtl/erg_stream_if.sv
rtl/erg_div_slice.sv
rtl/erg_pipe_ctl.sv
rtl/euclidean_rhythm_gate.sv
verif/euclidean_rhythm_gate_test.sv
